>>> src/assert_macros.svh
// Assertion macros shared by the heap queue RTL.
// Needs nothing else; define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> src/mhpq_pkg.sv
// Types, constants and helpers of the min-heap priority queue.
// Used by mhpq_cell and min_heap_priority_queue; depends on nothing.
`default_nettype none

package mhpq_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned CAPACITY_MAX = 4096;
  // Heap node numbers are 1-based: node = 2**level + index within level
  localparam int unsigned NODE_W       = $clog2(CAPACITY_MAX + 1);
  localparam int unsigned IDX_W        = NODE_W - 1;
  localparam int unsigned LVL_W        = $clog2(NODE_W);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_TAKE,
    S_RUN
  } state_t;

  typedef struct packed {
    logic req_type;
    key_t key_value;
  } in_word_t;

  typedef struct packed {
    key_t                min_value;
    status_t             status;
    logic [COUNT_W-1:0]  entry_count;
  } out_word_t;

  // Request travelling down the row of level cells
  typedef struct packed {
    logic             valid;
    logic             del;
    logic [IDX_W-1:0] idx;
    key_t             key;
  } token_t;

  // Write from a cell into its parent level
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    key_t             key;
  } wb_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              fetch;
    logic [LVL_W-1:0]  tgt;
    logic [NODE_W-1:0] node;
  } ctl_t;

  // Level of a node: position of its top set bit
  function automatic logic [LVL_W-1:0] msb_pos(input logic [NODE_W-1:0] v);
    logic [LVL_W-1:0] p;
    p = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (v[i]) p = LVL_W'(i);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

>>> src/mhpq_cell.sv
// One heap level: its slice of the key store and the compare step for that level.
// Depends on mhpq_pkg; chained by min_heap_priority_queue, one cell per level.
`default_nettype none

module mhpq_cell #(
  parameter int unsigned LEVEL  = 0,
  parameter int unsigned LEVELS = 7,
  parameter int unsigned CNT_W  = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  cnt,
  input  mhpq_pkg::ctl_t    ctl,
  input  mhpq_pkg::token_t  tok_in,
  output mhpq_pkg::token_t  tok_out,
  input  mhpq_pkg::wb_t     wb_in,
  output mhpq_pkg::wb_t     wb_out,
  output mhpq_pkg::key_t    rd_key,
  output logic              done
);
  import mhpq_pkg::*;

  localparam int unsigned AW    = (LEVEL == 0) ? 1 : LEVEL;
  localparam int unsigned DEPTH = 1 << AW;
  localparam logic [NODE_W-1:0] BASE = NODE_W'(2 ** LEVEL);
  localparam bit LAST = (LEVEL == LEVELS - 1);

  key_t              mem [DEPTH];
  logic [AW-1:0]     addr_a, addr_b;
  key_t              rd_a, rd_b;
  token_t            tok_d;
  token_t            tok_next;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  key_t              wr_data;
  logic              m_en;
  logic [AW-1:0]     m_addr;
  key_t              m_data;
  logic [NODE_W-1:0] cnt_n, node_l, node_r;
  logic              left_ok, right_ok, take_r;
  key_t              pick;
  logic [IDX_W-1:0]  pick_idx, ins_idx;
  logic [LVL_W-1:0]  sh;

  // Pick read addresses: path slot, both children, or the fetch slot
  always_comb begin
    addr_a = AW'(tok_in.idx);
    addr_b = addr_a;
    if (tok_in.del) begin
      addr_a = AW'({tok_in.idx, 1'b0});
      addr_b = AW'({tok_in.idx, 1'b1});
    end
    if (ctl.fetch) begin
      if (LEVEL == 0) addr_a = '0;
      else            addr_a = AW'(ctl.node);
    end
  end

  // Merge own write and the write coming up from the child level
  always_comb begin
    m_en   = wr_en | wb_in.en;
    m_addr = wb_in.en ? AW'(wb_in.idx) : wr_addr;
    m_data = wb_in.en ? wb_in.key : wr_data;
  end

  // Key store of this level
  always_ff @(posedge clk) begin
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
    if (m_en) mem[m_addr] <= m_data;
  end

  // Hold the request while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_d <= '0;
    end else begin
      tok_d <= tok_in;
    end
  end

  // Compare with the stored keys and decide what moves on
  always_comb begin
    cnt_n    = NODE_W'(cnt);
    node_l   = BASE | NODE_W'({tok_d.idx, 1'b0});
    node_r   = node_l | NODE_W'(1);
    left_ok  = (node_l <= cnt_n);
    right_ok = (node_r <= cnt_n);
    take_r   = right_ok && (rd_b < rd_a);
    pick     = take_r ? rd_b : rd_a;
    pick_idx = {tok_d.idx[IDX_W-2:0], take_r};
    sh       = ctl.tgt - LVL_W'(LEVEL) - LVL_W'(1);
    ins_idx  = {tok_d.idx[IDX_W-2:0], ctl.node[sh]};

    tok_next = '0;
    wb_out   = '0;
    wr_en    = 1'b0;
    wr_addr  = AW'(tok_d.idx);
    wr_data  = tok_d.key;
    done     = 1'b0;

    if (tok_d.valid) begin
      if (!tok_d.del) begin
        // insert: keep the smaller key on the path, carry the larger down
        if (ctl.tgt == LVL_W'(LEVEL)) begin
          wr_en = 1'b1;
          done  = 1'b1;
        end else begin
          tok_next.valid = 1'b1;
          tok_next.del   = 1'b0;
          tok_next.idx   = ins_idx;
          if (tok_d.key < rd_a) begin
            wr_en        = 1'b1;
            tok_next.key = rd_a;
          end else begin
            tok_next.key = tok_d.key;
          end
        end
      end else begin
        // delete: pull the smaller child up into the hole, or close the hole
        wb_out.en  = 1'b1;
        wb_out.idx = tok_d.idx;
        if (left_ok && (pick < tok_d.key)) begin
          wb_out.key = pick;
          if (LAST) begin
            wr_en   = 1'b1;
            wr_addr = AW'(pick_idx);
            done    = 1'b1;
          end else begin
            tok_next.valid = 1'b1;
            tok_next.del   = 1'b1;
            tok_next.idx   = pick_idx;
            tok_next.key   = tok_d.key;
          end
        end else begin
          wb_out.key = tok_d.key;
          done       = 1'b1;
        end
      end
    end
  end

  // Pass the request to the next level
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  assign rd_key = rd_a;

endmodule

`default_nettype wire

>>> src/min_heap_priority_queue.sv
// Min-heap priority queue: a row of level cells, each cell owning one heap level.
// Insert: the key walks down the cells, through each cell's read and pass registers, to the new slot's level.
// Delete-min: a fetch state and a take state, then the hole is sifted down level by level.
// Full insert or empty delete answers from the idle state. One request is in work at a time.
// Reset clears state, entry count and valid flags; the key store is not cleared and needs no pass.
`default_nettype none
`include "assert_macros.svh"

module min_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  mhpq_pkg::in_word_t  req_word,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output mhpq_pkg::out_word_t rsp_word
);
  import mhpq_pkg::*;

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned LEVELS = $clog2(CAPACITY + 1);

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [LVL_W-1:0]  tgt;
  logic [NODE_W-1:0] node, node_acc;
  logic              del_op;
  logic              load_ctl;
  key_t              root, root_next, last_key;
  token_t            tok0, tok0_next, dtok, dtok_next;
  logic              accept, fin, done_any;
  out_word_t         fin_word;
  ctl_t              ctl;

  token_t            cell_in  [LEVELS];
  token_t            cell_out [LEVELS];
  wb_t               wb_arr   [LEVELS];
  wb_t               wb_into  [LEVELS];
  key_t              rd_arr   [LEVELS];
  logic [LEVELS-1:0] done_vec;
  logic [LEVELS-1:0] tokv;

  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign done_any  = |done_vec;

  assign ctl.fetch = (state == S_FETCH);
  assign ctl.tgt   = tgt;
  assign ctl.node  = node;

  // Chain the level cells
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    if (l == 0) begin : g_in_root
      assign cell_in[l] = tok0;
    end else if (l == 1) begin : g_in_first
      assign cell_in[l] = dtok.valid ? dtok : cell_out[0];
    end else begin : g_in_rest
      assign cell_in[l] = cell_out[l-1];
    end

    if (l == LEVELS - 1) begin : g_wb_last
      assign wb_into[l] = '0;
    end else begin : g_wb_rest
      assign wb_into[l] = wb_arr[l+1];
    end

    assign tokv[l] = cell_in[l].valid;

    mhpq_cell #(
      .LEVEL  (l),
      .LEVELS (LEVELS),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cnt     (cnt),
      .ctl     (ctl),
      .tok_in  (cell_in[l]),
      .tok_out (cell_out[l]),
      .wb_in   (wb_into[l]),
      .wb_out  (wb_arr[l]),
      .rd_key  (rd_arr[l]),
      .done    (done_vec[l])
    );
  end

  // Select the last entry read during the fetch
  always_comb begin
    last_key = rd_arr[0];
    for (int l = 0; l < LEVELS; l++) begin
      if (tgt == LVL_W'(l)) last_key = rd_arr[l];
    end
  end

  // Next state and request launch
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    load_ctl   = 1'b0;
    root_next  = root;
    tok0_next  = '0;
    dtok_next  = '0;
    fin        = 1'b0;
    fin_word   = '0;
    node_acc   = (req_word.req_type == REQ_INSERT) ? NODE_W'(cnt) + NODE_W'(1)
                                                   : NODE_W'(cnt);
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_word.req_type == REQ_INSERT) begin
            if (cnt == CNT_W'(CAPACITY)) begin
              fin                  = 1'b1;
              fin_word.status      = ST_FULL;
              fin_word.entry_count = COUNT_W'(cnt);
            end else begin
              cnt_next        = cnt + CNT_W'(1);
              load_ctl        = 1'b1;
              tok0_next.valid = 1'b1;
              tok0_next.key   = req_word.key_value;
              state_next      = S_RUN;
            end
          end else begin
            if (cnt == '0) begin
              fin                  = 1'b1;
              fin_word.status      = ST_EMPTY;
              fin_word.entry_count = COUNT_W'(cnt);
            end else begin
              cnt_next   = cnt - CNT_W'(1);
              load_ctl   = 1'b1;
              state_next = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        state_next = S_TAKE;
      end
      S_TAKE: begin
        root_next = rd_arr[0];
        if (cnt == '0) begin
          fin                  = 1'b1;
          fin_word.min_value   = rd_arr[0];
          fin_word.status      = ST_OK;
          fin_word.entry_count = COUNT_W'(cnt);
          state_next           = S_IDLE;
        end else begin
          dtok_next.valid = 1'b1;
          dtok_next.del   = 1'b1;
          dtok_next.key   = last_key;
          state_next      = S_RUN;
        end
      end
      S_RUN: begin
        if (done_any) begin
          fin                  = 1'b1;
          fin_word.min_value   = del_op ? root : '0;
          fin_word.status      = ST_OK;
          fin_word.entry_count = COUNT_W'(cnt);
          state_next           = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Launch registers towards the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      tok0 <= '0;
      dtok <= '0;
    end else begin
      tok0 <= tok0_next;
      dtok <= dtok_next;
    end
  end

  // Hold the request's path and the removed root
  always_ff @(posedge clk) begin
    root <= root_next;
    if (load_ctl) begin
      node   <= node_acc;
      tgt    <= msb_pos(node_acc);
      del_op <= (req_word.req_type == REQ_DELETE);
    end
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (fin) rsp_word <= fin_word;
  end

  `ASSERT_ALWAYS(a_one_in_flight, clk, rst, $onehot0(tokv), "more than one request in the cells")
  `ASSERT_ALWAYS(a_cnt_cap, clk, rst, cnt <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `ASSERT_IMPLY(a_idle_quiet, clk, rst, state == S_IDLE, tokv == '0 && !done_any, "cells busy while idle")
  `ASSERT_IMPLY(a_done_in_run, clk, rst, done_any, state == S_RUN, "cell finished outside a run")
  `ASSERT_NEXT(a_done_rsp, clk, rst, done_any, rsp_valid, "finished request gave no result")

endmodule

`default_nettype wire
